FILE: hw/rtl/double_ended_ring_buffer_core_assert.svh
// assertion macros used by the ring buffer core
`ifndef DOUBLE_ENDED_RING_BUFFER_CORE_ASSERT_SVH
`define DOUBLE_ENDED_RING_BUFFER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DERB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ring buffer check failed");

// next-cycle implication, checked outside reset
`define DERB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ring buffer check failed");

`endif

FILE: hw/rtl/derb_pkg.sv
package derb_pkg;

    // storage geometry
    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 5;
    localparam int CMD_W  = 3;

    // stream payload widths
    localparam int IN_BITS    = DATA_W + ADDR_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 3 * DATA_W + CNT_W + 3;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;

    // ram read address select
    localparam logic [1:0] RD_SEL_INDEX = 2'd0;
    localparam logic [1:0] RD_SEL_FRONT = 2'd1;
    localparam logic [1:0] RD_SEL_BACK  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic       take;
        logic       exec;
        logic [1:0] rd_sel;
        logic       cap_read;
        logic       cap_front;
        logic       cap_back;
        logic       load;
    } t_dp_ctrl;

    // one result, read_data in the low bits
    typedef struct packed {
        logic              error;
        logic              dropped;
        logic              is_empty;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] back_data;
        logic [DATA_W-1:0] front_data;
        logic [DATA_W-1:0] read_data;
    } t_result;

    // physical slot of an offset from base, wrapping at DEPTH
    function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    // slot before base, wrapping at zero
    function automatic logic [ADDR_W-1:0] slot_prev(input logic [ADDR_W-1:0] base);
        logic [ADDR_W-1:0] res;
        if (base == '0) begin
            res = ADDR_W'(DEPTH - 1);
        end else begin
            res = base - 1'b1;
        end
        return res;
    endfunction

    // capacity register value, zero acts as one, large values as DEPTH
    function automatic logic [CNT_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
        logic [CNT_W-1:0] res;
        if (v == '0) begin
            res = CNT_W'(1);
        end else if (int'(v) > DEPTH) begin
            res = CNT_W'(DEPTH);
        end else begin
            res = CNT_W'(v);
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/double_ended_ring_buffer_core.sv
// commands are handled one at a time, paced by the single read port of the
// entry ram (index, front and back are read one after another)
// the result register lets the next command be taken while a result waits
// reset (synchronous, active low): empty buffer, head 0, capacity 16
module double_ended_ring_buffer_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [derb_pkg::CAP_W-1:0]         i_cfg_wr_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [derb_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // value, index, zero pad
    input  logic [derb_pkg::CMD_W-1:0]         s_axis_tuser,   // cmd
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // read_data, front_data, back_data, count, is_empty, dropped, error
    output logic [derb_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import derb_pkg::*;

    t_dp_ctrl ctrl;
    t_result  result;

    derb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s_valid(s_axis_tvalid),
        .o_s_ready(s_axis_tready),
        .o_m_valid(m_axis_tvalid),
        .i_m_ready(m_axis_tready),
        .o_ctrl   (ctrl)
    );

    derb_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_cmd        (s_axis_tuser),
        .i_value      (s_axis_tdata[DATA_W-1:0]),
        .i_index      (s_axis_tdata[DATA_W +: ADDR_W]),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .o_result     (result)
    );

    assign m_axis_tdata = OUT_TDATA_W'(result);

    // checks
    `include "double_ended_ring_buffer_core_assert.svh"

    `DERB_ASSERT_NOW(a_err_no_drop, i_clk, i_rst_n, m_axis_tvalid, !(result.error && result.dropped))
    `DERB_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, m_axis_tvalid && result.is_empty, result.front_data == '0 && result.back_data == '0 && result.count == '0)
    `DERB_ASSERT_NOW(a_count_max, i_clk, i_rst_n, m_axis_tvalid, int'(result.count) <= DEPTH)
    `DERB_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

FILE: hw/rtl/derb_ram.sv
module derb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: hw/rtl/derb_ctrl.sv
module derb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    output derb_pkg::t_dp_ctrl o_ctrl
);
    import derb_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_RD_INDEX = 3'd2;
    localparam logic [2:0] S_RD_FRONT = 3'd3;
    localparam logic [2:0] S_RD_BACK  = 3'd4;
    localparam logic [2:0] S_CAP_BACK = 3'd5;
    localparam logic [2:0] S_OUT      = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_m_valid;
    logic       n_m_valid;
    logic       out_free;
    t_dp_ctrl   ctrl;

    assign out_free = !r_m_valid || i_m_ready;

    // sequencer: execute, three ram reads, then hand the result over
    always_comb begin
        n_state = r_state;
        ctrl    = '0;
        ctrl.rd_sel = RD_SEL_INDEX;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    ctrl.take = 1'b1;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                ctrl.exec = 1'b1;
                n_state   = S_RD_INDEX;
            end
            S_RD_INDEX: begin
                ctrl.rd_sel = RD_SEL_INDEX;
                n_state     = S_RD_FRONT;
            end
            S_RD_FRONT: begin
                ctrl.rd_sel   = RD_SEL_FRONT;
                ctrl.cap_read = 1'b1;
                n_state       = S_RD_BACK;
            end
            S_RD_BACK: begin
                ctrl.rd_sel    = RD_SEL_BACK;
                ctrl.cap_front = 1'b1;
                n_state        = S_CAP_BACK;
            end
            S_CAP_BACK: begin
                ctrl.cap_back = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    ctrl.load = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        n_m_valid = r_m_valid;
        if (ctrl.load) begin
            n_m_valid = 1'b1;
        end else if (r_m_valid && i_m_ready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_m_valid;
    assign o_ctrl    = ctrl;
endmodule

FILE: hw/rtl/derb_dp.sv
module derb_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  derb_pkg::t_dp_ctrl            i_ctrl,
    input  logic [derb_pkg::CMD_W-1:0]    i_cmd,
    input  logic [derb_pkg::DATA_W-1:0]   i_value,
    input  logic [derb_pkg::ADDR_W-1:0]   i_index,
    input  logic                          i_cfg_wr_en,
    input  logic [derb_pkg::CAP_W-1:0]    i_cfg_wr_data,
    output derb_pkg::t_result             o_result
);
    import derb_pkg::*;

    // item registers
    logic [CMD_W-1:0]  r_cmd;
    logic [DATA_W-1:0] r_value;
    logic [ADDR_W-1:0] r_index;

    // buffer state
    logic [ADDR_W-1:0] r_head;
    logic [ADDR_W-1:0] n_head;
    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  n_fill;
    logic [CNT_W-1:0]  r_cap;
    logic [CNT_W-1:0]  n_cap;
    logic              r_drop;
    logic              n_drop;
    logic              r_err;
    logic              n_err;

    // captured ram words and the result
    logic [DATA_W-1:0] r_read_word;
    logic [DATA_W-1:0] r_front_word;
    logic [DATA_W-1:0] r_back_word;
    t_result           r_result;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic [CNT_W-1:0]  cfg_cap;
    logic              full;

    assign full    = (r_fill >= r_cap);
    assign cfg_cap = clamp_cap(i_cfg_wr_data);

    // command execution and capacity writes
    always_comb begin
        n_head  = r_head;
        n_fill  = r_fill;
        n_cap   = r_cap;
        n_drop  = r_drop;
        n_err   = r_err;
        wr_en   = 1'b0;
        wr_addr = slot_add(r_head, r_fill);
        if (i_ctrl.exec) begin
            n_drop = 1'b0;
            n_err  = 1'b0;
            case (r_cmd)
                CMD_PUSH_BACK: begin
                    wr_en = 1'b1;
                    if (full) begin
                        n_head = slot_add(r_head, CNT_W'(1));
                        n_drop = 1'b1;
                    end else begin
                        n_fill = r_fill + 1'b1;
                    end
                end
                CMD_PUSH_FRONT: begin
                    wr_en   = 1'b1;
                    wr_addr = slot_prev(r_head);
                    n_head  = slot_prev(r_head);
                    if (full) begin
                        n_drop = 1'b1;
                    end else begin
                        n_fill = r_fill + 1'b1;
                    end
                end
                CMD_POP_BACK: begin
                    if (r_fill == '0) begin
                        n_err = 1'b1;
                    end else begin
                        n_fill = r_fill - 1'b1;
                    end
                end
                CMD_POP_FRONT: begin
                    if (r_fill == '0) begin
                        n_err = 1'b1;
                    end else begin
                        n_head = slot_add(r_head, CNT_W'(1));
                        n_fill = r_fill - 1'b1;
                    end
                end
                CMD_READ: begin
                    if (CNT_W'(r_index) >= r_fill) begin
                        n_err = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cfg_wr_en) begin
            // lowering the capacity drops entries at the back
            n_cap = cfg_cap;
            if (r_fill > cfg_cap) begin
                n_fill = cfg_cap;
            end
        end
    end

    // read address select
    always_comb begin
        case (i_ctrl.rd_sel)
            RD_SEL_INDEX: rd_addr = slot_add(r_head, CNT_W'(r_index));
            RD_SEL_FRONT: rd_addr = r_head;
            RD_SEL_BACK:  rd_addr = slot_add(r_head, r_fill - 1'b1);
            default:      rd_addr = r_head;
        endcase
    end

    derb_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(r_value),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
            r_cap  <= CNT_W'(DEPTH);
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
            r_cap  <= n_cap;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_drop <= n_drop;
        r_err  <= n_err;
        if (i_ctrl.take) begin
            r_cmd   <= i_cmd;
            r_value <= i_value;
            r_index <= i_index;
        end
        if (i_ctrl.cap_read) begin
            r_read_word <= rd_data;
        end
        if (i_ctrl.cap_front) begin
            r_front_word <= rd_data;
        end
        if (i_ctrl.cap_back) begin
            r_back_word <= rd_data;
        end
        if (i_ctrl.load) begin
            r_result.read_data  <= (r_cmd == CMD_READ && !r_err) ? r_read_word : '0;
            r_result.front_data <= (r_fill != '0) ? r_front_word : '0;
            r_result.back_data  <= (r_fill != '0) ? r_back_word : '0;
            r_result.count      <= r_fill;
            r_result.is_empty   <= (r_fill == '0);
            r_result.dropped    <= r_drop;
            r_result.error      <= r_err;
        end
    end

    assign o_result = r_result;
endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import derb_pkg::*;

    // codes with no operation behind them
    localparam logic [CMD_W-1:0] CMD_UNDEF_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNDEF_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNDEF_C = 3'd7;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CAP_W-1:0]       i_cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // value, index, zero pad
    logic [CMD_W-1:0]       s_axis_tuser;   // cmd
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // read_data, front_data, back_data, count, is_empty, dropped, error
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // shadow copy of the buffer contents and pointers
    logic [DATA_W-1:0] ring_mem [DEPTH];
    logic [ADDR_W-1:0] ring_head;
    logic [CNT_W-1:0]  ring_fill;
    logic [CNT_W-1:0]  ring_cap;

    t_result ring_expect_q [$];
    int      mismatch_cnt = 0;
    bit      idle_on;
    int      stall_left;

    double_ended_ring_buffer_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // physical slot at an offset from the front
    function automatic logic [ADDR_W-1:0] ring_slot(input int off);
        return ADDR_W'((int'(ring_head) + off) % DEPTH);
    endfunction

    function automatic void ring_reset();
        for (int k = 0; k < DEPTH; k++) begin
            ring_mem[k] = '0;
        end
        ring_head = '0;
        ring_fill = '0;
        ring_cap  = CNT_W'(DEPTH);
    endfunction

    // capacity write: zero acts as one, large values as the depth, fill trimmed at the back
    function automatic void ring_set_capacity(input logic [CAP_W-1:0] v);
        if (v == '0) begin
            ring_cap = CNT_W'(1);
        end else if (int'(v) > DEPTH) begin
            ring_cap = CNT_W'(DEPTH);
        end else begin
            ring_cap = CNT_W'(v);
        end
        if (ring_fill > ring_cap) begin
            ring_fill = ring_cap;
        end
    endfunction

    // applies one command to the shadow buffer and returns the status it should report
    function automatic t_result ring_apply_cmd(input logic [CMD_W-1:0] cmd,
                                               input logic [DATA_W-1:0] value,
                                               input logic [ADDR_W-1:0] index);
        t_result r;
        logic    full;
        r    = '0;
        full = (ring_fill >= ring_cap);
        case (cmd)
            CMD_PUSH_BACK: begin
                ring_mem[ring_slot(int'(ring_fill))] = value;
                if (full) begin
                    ring_head = ring_slot(1);
                    r.dropped = 1'b1;
                end else begin
                    ring_fill = ring_fill + 1'b1;
                end
            end
            CMD_PUSH_FRONT: begin
                ring_head = (ring_head == '0) ? ADDR_W'(DEPTH - 1) : ring_head - 1'b1;
                ring_mem[ring_head] = value;
                if (full) begin
                    r.dropped = 1'b1;
                end else begin
                    ring_fill = ring_fill + 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (ring_fill == '0) begin
                    r.error = 1'b1;
                end else begin
                    ring_fill = ring_fill - 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (ring_fill == '0) begin
                    r.error = 1'b1;
                end else begin
                    ring_head = ring_slot(1);
                    ring_fill = ring_fill - 1'b1;
                end
            end
            CMD_READ: begin
                if (CNT_W'(index) >= ring_fill) begin
                    r.error = 1'b1;
                end else begin
                    r.read_data = ring_mem[ring_slot(int'(index))];
                end
            end
            default: ;
        endcase
        if (ring_fill != '0) begin
            r.front_data = ring_mem[ring_head];
            r.back_data  = ring_mem[ring_slot(int'(ring_fill) - 1)];
        end
        r.count    = ring_fill;
        r.is_empty = (ring_fill == '0);
        return r;
    endfunction

    // gap length: mostly none, often short, now and then long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (!idle_on || p < 60) begin
            return 0;
        end else if (p < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 25);
    endfunction

    // one command transaction on the input side, expectation queued at acceptance
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value,
                            input logic [ADDR_W-1:0] index);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= IN_TDATA_W'({index, value});
        do @(posedge i_clk); while (!s_axis_tready);
        ring_expect_q.insert(ring_expect_q.size(), ring_apply_cmd(cmd, value, index));
    endtask

    // let the block drain, then write the capacity register
    task automatic write_capacity(input logic [CAP_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (ring_expect_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        ring_set_capacity(v);
    endtask

    // output side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 99) < 25) begin
            m_axis_tready <= 1'b0;
            stall_left    <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                          : $urandom_range(7, 24);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [DATA_W-1:0] exp_v,
                               input logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            mismatch_cnt++;
        end
    endtask

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_result act, exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            act = t_result'(m_axis_tdata[OUT_BITS-1:0]);
            if (ring_expect_q.size() == 0) begin
                $error("result with no command outstanding");
                mismatch_cnt++;
            end else begin
                exp_r = ring_expect_q[0];
                ring_expect_q.delete(0);
                check_field("read_data", exp_r.read_data, act.read_data);
                check_field("front_data", exp_r.front_data, act.front_data);
                check_field("back_data", exp_r.back_data, act.back_data);
                check_field("count", DATA_W'(exp_r.count), DATA_W'(act.count));
                check_field("is_empty", DATA_W'(exp_r.is_empty), DATA_W'(act.is_empty));
                check_field("dropped", DATA_W'(exp_r.dropped), DATA_W'(act.dropped));
                check_field("error", DATA_W'(exp_r.error), DATA_W'(act.error));
            end
        end
    end

    // pops, reads and unused codes on an empty buffer
    task automatic test_empty_buffer();
        send_cmd(CMD_POP_BACK, $urandom, '0);
        send_cmd(CMD_POP_FRONT, $urandom, '0);
        send_cmd(CMD_READ, '0, '0);
        send_cmd(CMD_READ, '1, '1);
        send_cmd(CMD_UNDEF_A, $urandom, '0);
        send_cmd(CMD_UNDEF_B, $urandom, '1);
        send_cmd(CMD_UNDEF_C, $urandom, 4'd3);
    endtask

    // both pushes with extreme values, reads in and past range
    task automatic test_push_and_read();
        send_cmd(CMD_PUSH_BACK, '1, '1);
        send_cmd(CMD_PUSH_FRONT, '0, '0);
        send_cmd(CMD_PUSH_BACK, $urandom, '0);
        send_cmd(CMD_READ, $urandom, 4'd0);
        send_cmd(CMD_READ, $urandom, 4'd2);
        send_cmd(CMD_READ, $urandom, 4'd3);
    endtask

    // pushes on a full buffer drop the entry at the other end
    task automatic test_overwrite();
        write_capacity(5'd2);
        send_cmd(CMD_PUSH_BACK, $urandom, '0);
        send_cmd(CMD_PUSH_BACK, $urandom, '0);
        send_cmd(CMD_PUSH_BACK, $urandom, '0);
        send_cmd(CMD_PUSH_FRONT, $urandom, '0);
        send_cmd(CMD_READ, $urandom, 4'd1);
    endtask

    // capacity zero, above the depth, and lowered below the fill
    task automatic test_capacity_limits();
        write_capacity(5'd0);
        send_cmd(CMD_PUSH_BACK, $urandom, '0);
        send_cmd(CMD_PUSH_FRONT, $urandom, '0);
        write_capacity(5'd17);
        send_cmd(CMD_PUSH_BACK, $urandom, '0);
        write_capacity(5'd1);
        send_cmd(CMD_READ, $urandom, 4'd1);
        send_cmd(CMD_POP_BACK, $urandom, '0);
        send_cmd(CMD_POP_FRONT, $urandom, '0);
    endtask

    // random command mix, reads mostly inside the held range
    task automatic test_random_mix(input logic [CAP_W-1:0] cap, input int n);
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] index;
        int                p;
        write_capacity(cap);
        for (int k = 0; k < n; k++) begin
            p = $urandom_range(0, 99);
            if (p < 25) begin
                cmd = CMD_PUSH_BACK;
            end else if (p < 45) begin
                cmd = CMD_PUSH_FRONT;
            end else if (p < 60) begin
                cmd = CMD_POP_BACK;
            end else if (p < 75) begin
                cmd = CMD_POP_FRONT;
            end else if (p < 95) begin
                cmd = CMD_READ;
            end else begin
                cmd = CMD_W'($urandom_range(CMD_UNDEF_A, CMD_UNDEF_C));
            end
            if (ring_fill != '0 && $urandom_range(0, 3) != 0) begin
                index = ADDR_W'($urandom_range(0, int'(ring_fill) - 1));
            end else begin
                index = ADDR_W'($urandom_range(0, DEPTH - 1));
            end
            send_cmd(cmd, $urandom, index);
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        idle_on       = 1'b0;
        ring_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_buffer();
        idle_on = 1'b1;
        test_push_and_read();
        test_overwrite();
        test_capacity_limits();

        // phases alternate between traffic with gaps and stalls and back-to-back traffic
        test_random_mix(5'd16, 60);
        idle_on = 1'b0;
        test_random_mix(5'd31, 50);
        idle_on = 1'b1;
        test_random_mix(5'd1, 40);
        test_random_mix(5'd5, 50);
        idle_on = 1'b0;
        test_random_mix(5'd0, 30);
        idle_on = 1'b1;
        test_random_mix(5'd20, 60);
        test_random_mix(CAP_W'($urandom_range(0, 31)), 50);
        test_random_mix(5'd3, 30);
        test_random_mix(5'd16, 40);

        // drain and settle
        s_axis_tvalid <= 1'b0;
        while (ring_expect_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: double_ended_ring_buffer_core.f
+incdir+hw/rtl
hw/rtl/derb_pkg.sv
hw/rtl/derb_ram.sv
hw/rtl/derb_ctrl.sv
hw/rtl/derb_dp.sv
hw/rtl/double_ended_ring_buffer_core.sv
tb/sv/tb_top.sv
